// File: design/tbcw_pkg.sv
// Shared types and constants for the tile blitter with clip window.
// Holds the request, response, queue entry and configuration types.
// No dependencies.
package tbcw_pkg;

    // Signed coordinate wide enough for origin + column + clip origin + scroll
    localparam int XY_W = 18;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_CLIP_ENABLE  = 3'd0;
    localparam logic [2:0] REG_CLIP_LEFT    = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP     = 3'd2;
    localparam logic [2:0] REG_CLIP_RIGHT   = 3'd3;
    localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd4;
    localparam logic [2:0] REG_CLIP_SHIFT_X = 3'd5;
    localparam logic [2:0] REG_CLIP_SHIFT_Y = 3'd6;

    localparam logic CMD_BITMAP = 1'b0;
    localparam logic CMD_COLOR  = 1'b1;

    typedef logic signed [XY_W-1:0] coord_t;

    typedef struct packed {
        logic               cmd;
        logic               first;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic               pixel_bit;
        logic [31:0]        pixel_color;
        logic [31:0]        fg_color;
        logic [31:0]        bg_color;
        logic               skip_background;
        logic [31:0]        key_color;
    } req_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [31:0] write_color;
        logic        tile_done;
    } rsp_t;

    typedef struct packed {
        logic               clip_enable;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
        logic signed [15:0] clip_shift_x;
        logic signed [15:0] clip_shift_y;
    } cfg_t;

    // Classified pixel handed from the front to the back
    typedef struct packed {
        logic        drawn;
        logic        done;
        logic [31:0] color;
        coord_t      x;
        coord_t      y;
    } entry_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

    function automatic coord_t sext16(logic signed [15:0] v);
        return {{(XY_W-16){v[15]}}, v};
    endfunction

endpackage

// File: design/tbcw_front.sv
// Front end: accepts pixel words, tracks the tile position and classifies
// each pixel into a queue entry with its screen coordinates.
// Depends on tbcw_pkg.
module tbcw_front #(
    parameter int TILE_SIZE = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tbcw_pkg::req_t   req,
    input  tbcw_pkg::cfg_t   cfg,
    input  tbcw_pkg::q_stat_t q_stat,
    output logic             push,
    output tbcw_pkg::entry_t push_entry
);

    localparam int CW = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam logic [CW-1:0] LAST = CW'(TILE_SIZE - 1);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_cur, row_cur;
    tbcw_pkg::coord_t x_base, y_base, x_off, y_off;

    assign req_ready = !q_stat.full;
    assign push      = req_valid && req_ready;

    // A first pixel restarts the tile before it is placed
    assign col_cur = req.first ? '0 : col_reg;
    assign row_cur = req.first ? '0 : row_reg;

    always_comb
    begin
        col_next = col_cur + CW'(1);
        row_next = row_cur;
        if (col_cur == LAST)
        begin
            col_next = '0;
            row_next = (row_cur == LAST) ? '0 : row_cur + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        x_base = tbcw_pkg::sext16(req.origin_x) + tbcw_pkg::coord_t'(col_cur);
        y_base = tbcw_pkg::sext16(req.origin_y) + tbcw_pkg::coord_t'(row_cur);
        x_off  = '0;
        y_off  = '0;
        if (cfg.clip_enable)
        begin
            x_off = tbcw_pkg::sext16(cfg.clip_left) + tbcw_pkg::sext16(cfg.clip_shift_x);
            y_off = tbcw_pkg::sext16(cfg.clip_top) + tbcw_pkg::sext16(cfg.clip_shift_y);
        end

        push_entry.x    = x_base + x_off;
        push_entry.y    = y_base + y_off;
        push_entry.done = (col_cur == LAST) && (row_cur == LAST);
        if (req.cmd == tbcw_pkg::CMD_BITMAP)
        begin
            push_entry.drawn = req.pixel_bit || !req.skip_background;
            push_entry.color = req.pixel_bit ? req.fg_color : req.bg_color;
        end
        else
        begin
            push_entry.drawn = req.pixel_color != req.key_color;
            push_entry.color = req.pixel_color;
        end
    end

endmodule

// File: design/tbcw_queue.sv
// Two-entry queue between the front and back ends.
// Depends on tbcw_pkg.
module tbcw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbcw_pkg::entry_t  push_entry,
    input  logic              pop,
    output tbcw_pkg::entry_t  head,
    output tbcw_pkg::q_stat_t stat
);

    tbcw_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       level_reg, level_next;

    assign stat.full     = level_reg == 2'd2;
    assign stat.nonempty = level_reg != 2'd0;
    assign head          = slot_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 2'd1;
        else if (pop && !push)
            level_next = level_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: design/tbcw_back.sv
// Back end: bounds-checks a queued pixel against the clip window and frame
// buffer, forms the write address and holds the result in the output register.
// Depends on tbcw_pkg.
module tbcw_back #(
    parameter int BUF_WIDTH  = 256,
    parameter int BUF_HEIGHT = 192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbcw_pkg::cfg_t    cfg,
    input  tbcw_pkg::entry_t  head,
    input  tbcw_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tbcw_pkg::rsp_t    rsp
);

    localparam tbcw_pkg::coord_t X_LIM = tbcw_pkg::coord_t'(BUF_WIDTH);
    localparam tbcw_pkg::coord_t Y_LIM = tbcw_pkg::coord_t'(BUF_HEIGHT);
    localparam logic [15:0] WIDTH16 = 16'(BUF_WIDTH);

    logic           rsp_valid_reg;
    tbcw_pkg::rsp_t rsp_reg, rsp_next;
    logic           in_buf, in_clip, hit;
    logic [15:0]    addr;

    assign pop       = q_stat.nonempty && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        in_buf = (head.x >= 0) && (head.y >= 0) && (head.x < X_LIM) && (head.y < Y_LIM);
        in_clip = 1'b1;
        if (cfg.clip_enable)
            in_clip = (head.x >= tbcw_pkg::sext16(cfg.clip_left))
                   && (head.y >= tbcw_pkg::sext16(cfg.clip_top))
                   && (head.x <= tbcw_pkg::sext16(cfg.clip_right))
                   && (head.y <= tbcw_pkg::sext16(cfg.clip_bottom));
        hit  = head.drawn && in_buf && in_clip;
        // Only the low 16 bits of the address are kept
        addr = 16'(head.y[15:0] * WIDTH16) + head.x[15:0];

        rsp_next.write_valid   = hit;
        rsp_next.write_address = hit ? addr : 16'd0;
        rsp_next.write_color   = hit ? head.color : 32'd0;
        rsp_next.tile_done     = head.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (pop)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_reg <= rsp_next;
    end

endmodule

// File: design/tile_blitter_with_clip_window.sv
// Tile blitter with clip window. Takes one tile pixel word per clock in raster
// order while the input is ready and returns one frame-buffer write word per
// pixel, in order. Sustained rate is one pixel per cycle while the output is
// not held off. The accepting edge writes the classified pixel into a two-entry
// queue, and a later edge moves it through bounds check and address multiply
// into the output register once that register is empty or its word is taken.
// The input stays ready while the queue has room, so with the output held off
// the block keeps three words (one in the output register, two queued) and then
// blocks input. Clip registers sit on an APB-style port at byte addresses
// 4*index and must be written only while the block is idle.
module tile_blitter_with_clip_window #(
    parameter int TILE_SIZE  = 8,
    parameter int BUF_WIDTH  = 256,
    parameter int BUF_HEIGHT = 192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  tbcw_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output tbcw_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbcw_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    tbcw_pkg::cfg_t    cfg_reg;
    tbcw_pkg::entry_t  push_entry, head;
    tbcw_pkg::q_stat_t q_stat;
    logic              push, pop;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr)
        begin
            case (reg_idx)
                tbcw_pkg::REG_CLIP_ENABLE:  cfg_reg.clip_enable  <= pwdata[0];
                tbcw_pkg::REG_CLIP_LEFT:    cfg_reg.clip_left    <= pwdata[15:0];
                tbcw_pkg::REG_CLIP_TOP:     cfg_reg.clip_top     <= pwdata[15:0];
                tbcw_pkg::REG_CLIP_RIGHT:   cfg_reg.clip_right   <= pwdata[15:0];
                tbcw_pkg::REG_CLIP_BOTTOM:  cfg_reg.clip_bottom  <= pwdata[15:0];
                tbcw_pkg::REG_CLIP_SHIFT_X: cfg_reg.clip_shift_x <= pwdata[15:0];
                tbcw_pkg::REG_CLIP_SHIFT_Y: cfg_reg.clip_shift_y <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tbcw_pkg::REG_CLIP_ENABLE:  prdata = {31'd0, cfg_reg.clip_enable};
            tbcw_pkg::REG_CLIP_LEFT:    prdata = {16'd0, cfg_reg.clip_left};
            tbcw_pkg::REG_CLIP_TOP:     prdata = {16'd0, cfg_reg.clip_top};
            tbcw_pkg::REG_CLIP_RIGHT:   prdata = {16'd0, cfg_reg.clip_right};
            tbcw_pkg::REG_CLIP_BOTTOM:  prdata = {16'd0, cfg_reg.clip_bottom};
            tbcw_pkg::REG_CLIP_SHIFT_X: prdata = {16'd0, cfg_reg.clip_shift_x};
            tbcw_pkg::REG_CLIP_SHIFT_Y: prdata = {16'd0, cfg_reg.clip_shift_y};
            default:                    prdata = 32'd0;
        endcase
    end

    tbcw_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    tbcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    tbcw_back #(
        .BUF_WIDTH  (BUF_WIDTH),
        .BUF_HEIGHT (BUF_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Skipped or clipped pixels carry zero address and color
    a_blank_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.write_valid |-> rsp.write_address == 16'd0 && rsp.write_color == 32'd0)
        else $error("missed pixel carries nonzero address or color");

    // A first pixel never closes a tile when TILE_SIZE is above one
    a_first_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        push && req.first |-> !push_entry.done)
        else $error("first pixel marked as tile end");

    // A word pushed without a pop leaves the queue occupied
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> q_stat.nonempty)
        else $error("queue lost a word");

    // A word popped always lands in the output register
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp_valid)
        else $error("popped word not presented");

endmodule
